### rtl/core/btsc_pkg.sv
// Shared types, codes and helpers for the boundary tag size codec.
package btsc_pkg;

    localparam int SIZE_BITS_DEF      = 32;
    localparam int MAX_CODE_BYTES_DEF = 5;

    localparam logic [1:0] OP_ENC_PAYLOAD  = 2'd0;
    localparam logic [1:0] OP_ENC_INTERNAL = 2'd1;
    localparam logic [1:0] OP_DEC_LEFT     = 2'd2;
    localparam logic [1:0] OP_DEC_RIGHT    = 2'd3;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [31:0] size_value;
        logic        free_flag;
        logic [7:0]  code_byte;
    } t_in_beat;

    typedef struct packed {
        logic [7:0]  out_byte;
        logic [31:0] size_out;
        logic        free_out;
        logic [2:0]  code_len;
        logic        last;
        logic        overflow;
    } t_out_beat;

    typedef struct packed {
        logic accept;
        logic search_step;
        logic emit_byte;
        logic load_error;
    } t_cmd;

    typedef struct packed {
        logic out_free;
        logic go_search;
        logic go_emit;
        logic srch_done;
        logic srch_err;
        logic emit_last;
    } t_sts;

    // Bytes needed for a payload: 6 bits in the left byte, 7 in each further one.
    function automatic logic [2:0] needed_len(input logic [31:0] v);
        logic [2:0] n;
        if (v < 32'h0000_0040) begin
            n = 3'd1;
        end else if (v < 32'h0000_2000) begin
            n = 3'd2;
        end else if (v < 32'h0010_0000) begin
            n = 3'd3;
        end else if (v < 32'h0800_0000) begin
            n = 3'd4;
        end else begin
            n = 3'd5;
        end
        return n;
    endfunction

endpackage

### rtl/core/btsc_chan_if.sv
// Valid/ready channel carrying one payload beat.
interface btsc_chan_if #(
    parameter type t_payload = logic
) ();
    logic     valid;
    logic     ready;
    t_payload payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

### rtl/core/btsc_ctrl.sv
// Controller state machine sequencing accept, length search and byte emission.
module btsc_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    input  btsc_pkg::t_sts  i_sts,
    output btsc_pkg::t_cmd  o_cmd
);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_SEARCH = 2'd1;
    localparam logic [1:0] ST_EMIT   = 2'd2;
    localparam logic [1:0] ST_ERROR  = 2'd3;

    logic [1:0] r_state;
    logic [1:0] n_state;

    assign o_in_ready = (r_state == ST_IDLE) && i_sts.out_free;

    always_comb begin
        n_state           = r_state;
        o_cmd             = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (o_in_ready && i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    if (i_sts.go_search) begin
                        n_state = ST_SEARCH;
                    end else if (i_sts.go_emit) begin
                        n_state = ST_EMIT;
                    end
                end
            end
            ST_SEARCH: begin
                o_cmd.search_step = 1'b1;
                if (i_sts.srch_done) begin
                    n_state = ST_EMIT;
                end else if (i_sts.srch_err) begin
                    n_state = ST_ERROR;
                end
            end
            ST_EMIT: begin
                if (i_sts.out_free) begin
                    o_cmd.emit_byte = 1'b1;
                    if (i_sts.emit_last) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            ST_ERROR: begin
                if (i_sts.out_free) begin
                    o_cmd.load_error = 1'b1;
                    n_state          = ST_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    a_search_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.accept && i_sts.go_search |=> r_state == ST_SEARCH)
        else $error("internal-size encode did not enter length search");

    a_emit_exit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_EMIT && i_sts.out_free && i_sts.emit_last |=> r_state == ST_IDLE)
        else $error("encode did not finish after its last byte");

    a_error_exit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_ERROR && i_sts.out_free |=> r_state == ST_IDLE)
        else $error("error beat did not return the sequencer to idle");

endmodule

### rtl/core/btsc_dp.sv
// Datapath: decode state, encode registers, length search and output register.
module btsc_dp #(
    parameter int SIZE_BITS      = btsc_pkg::SIZE_BITS_DEF,
    parameter int MAX_CODE_BYTES = btsc_pkg::MAX_CODE_BYTES_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  btsc_pkg::t_in_beat   i_in_beat,
    input  btsc_pkg::t_cmd       i_cmd,
    input  logic                 i_out_ready,
    output btsc_pkg::t_sts       o_sts,
    output logic                 o_out_valid,
    output btsc_pkg::t_out_beat  o_out_beat
);

    localparam int ACC_BITS = (SIZE_BITS < 32) ? SIZE_BITS : 32;
    localparam int CNT_W    = $clog2(MAX_CODE_BYTES + 1);
    localparam int N_W      = $clog2(MAX_CODE_BYTES + 2);
    localparam int SH_W     = $clog2(7 * MAX_CODE_BYTES);
    localparam int WIDE_W   = ACC_BITS + 7 * MAX_CODE_BYTES;
    localparam logic [31:0] LIMIT_MASK =
        (ACC_BITS >= 32) ? 32'hFFFF_FFFF : 32'((64'd1 << ACC_BITS) - 64'd1);

    localparam logic [1:0] DIR_IDLE  = 2'd0;
    localparam logic [1:0] DIR_LEFT  = 2'd1;
    localparam logic [1:0] DIR_RIGHT = 2'd2;

    // decode state
    logic [ACC_BITS-1:0] r_acc, n_acc;
    logic [CNT_W-1:0]    r_cnt, n_cnt;
    logic [1:0]          r_dir, n_dir;
    logic                r_free_dec, n_free_dec;
    logic                r_ovf, n_ovf;

    // encode state
    logic [31:0]      r_v;
    logic [N_W-1:0]   r_n;
    logic [31:0]      r_pay;
    logic [CNT_W-1:0] r_rem;
    logic             r_first;
    logic             r_free_enc;

    // output register
    logic                r_out_valid;
    btsc_pkg::t_out_beat r_out;

    logic                w_in_range;
    logic [2:0]          w_need;
    logic                w_need_ok;
    logic                w_is_enc;
    logic [31:0]         w_two_n;
    logic [31:0]         w_pay_try;
    logic [2:0]          w_try_need;
    logic                w_n_over;
    logic                w_break;
    logic [SH_W-1:0]     w_shift;
    logic [31:0]         w_group;
    logic [7:0]          w_enc_byte;
    logic [1:0]          w_dir_op;
    logic [SH_W-1:0]     w_dec_shift;
    logic [6:0]          w_bits;
    logic [WIDE_W-1:0]   w_placed;
    logic                w_dec_fin;
    logic                w_fin_ovf;
    logic                w_ovf_new;
    logic                w_load;
    btsc_pkg::t_out_beat w_res;

    // accept-side checks
    assign w_in_range = ~|(i_in_beat.size_value & ~LIMIT_MASK);
    assign w_need     = btsc_pkg::needed_len(i_in_beat.size_value);
    assign w_need_ok  = 8'(w_need) <= 8'(MAX_CODE_BYTES);
    assign w_is_enc   = (i_in_beat.opcode == btsc_pkg::OP_ENC_PAYLOAD) ||
                        (i_in_beat.opcode == btsc_pkg::OP_ENC_INTERNAL);

    // length search: one candidate length per cycle
    assign w_two_n    = 32'({r_n, 1'b0});
    assign w_pay_try  = (r_v >= w_two_n) ? (r_v - w_two_n) : 32'd0;
    assign w_try_need = btsc_pkg::needed_len(w_pay_try);
    assign w_n_over   = 8'(r_n) > 8'(MAX_CODE_BYTES);
    assign w_break    = (8'(w_try_need) <= 8'(r_n)) || w_n_over;

    // byte emission, left to right
    assign w_shift = SH_W'(7 * r_rem);
    assign w_group = r_pay >> w_shift;

    always_comb begin
        if (r_n == N_W'(1)) begin
            w_enc_byte = {1'b1, r_free_enc, r_pay[5:0]};
        end else if (r_first) begin
            w_enc_byte = {1'b0, r_free_enc, w_group[5:0]};
        end else if (r_rem == '0) begin
            w_enc_byte = {1'b0, w_group[6:0]};
        end else begin
            w_enc_byte = {1'b1, w_group[6:0]};
        end
    end

    assign o_sts.out_free  = !r_out_valid || i_out_ready;
    assign o_sts.go_search = (i_in_beat.opcode == btsc_pkg::OP_ENC_INTERNAL) && w_in_range;
    assign o_sts.go_emit   = (i_in_beat.opcode == btsc_pkg::OP_ENC_PAYLOAD) &&
                             w_in_range && w_need_ok;
    assign o_sts.srch_done = w_break && !w_n_over;
    assign o_sts.srch_err  = w_break && w_n_over;
    assign o_sts.emit_last = (r_rem == '0);

    // decode step for one tag byte
    assign w_dir_op    = (i_in_beat.opcode == btsc_pkg::OP_DEC_LEFT) ? DIR_LEFT : DIR_RIGHT;
    assign w_dec_shift = SH_W'(7 * r_cnt);
    assign w_bits      = i_in_beat.code_byte[7] ? i_in_beat.code_byte[6:0]
                                                : {1'b0, i_in_beat.code_byte[5:0]};
    assign w_placed    = WIDE_W'(w_bits) << w_dec_shift;

    always_comb begin
        n_acc      = r_acc;
        n_cnt      = r_cnt;
        n_dir      = r_dir;
        n_free_dec = r_free_dec;
        n_ovf      = r_ovf;
        w_dec_fin  = 1'b0;
        w_fin_ovf  = 1'b0;
        w_ovf_new  = r_ovf;
        if (r_dir != w_dir_op) begin
            // new tag, abandoning any decode running the other way
            n_cnt = CNT_W'(1);
            n_ovf = 1'b0;
            if (i_in_beat.code_byte[7]) begin
                n_acc      = ACC_BITS'(i_in_beat.code_byte[5:0]);
                n_free_dec = i_in_beat.code_byte[6];
                w_dec_fin  = 1'b1;
            end else begin
                n_dir = w_dir_op;
                if (w_dir_op == DIR_LEFT) begin
                    n_acc      = ACC_BITS'(i_in_beat.code_byte[5:0]);
                    n_free_dec = i_in_beat.code_byte[6];
                end else begin
                    n_acc      = ACC_BITS'(i_in_beat.code_byte[6:0]);
                    n_free_dec = 1'b0;
                end
            end
        end else if (r_dir == DIR_LEFT) begin
            w_ovf_new = r_ovf | (|r_acc[ACC_BITS-1 -: 7]);
            n_ovf     = w_ovf_new;
            n_acc     = {r_acc[ACC_BITS-8:0], i_in_beat.code_byte[6:0]};
            n_cnt     = r_cnt + CNT_W'(1);
            if (!i_in_beat.code_byte[7]) begin
                w_dec_fin = 1'b1;
                w_fin_ovf = w_ovf_new;
            end else if (n_cnt >= CNT_W'(MAX_CODE_BYTES)) begin
                w_dec_fin = 1'b1;
                w_fin_ovf = 1'b1;
            end
        end else begin
            // walking from the right: drop bits past the size range
            w_ovf_new = r_ovf | (|w_placed[WIDE_W-1:ACC_BITS]);
            n_ovf     = w_ovf_new;
            n_acc     = r_acc | w_placed[ACC_BITS-1:0];
            n_cnt     = r_cnt + CNT_W'(1);
            if (i_in_beat.code_byte[7]) begin
                if (n_cnt >= CNT_W'(MAX_CODE_BYTES)) begin
                    w_dec_fin = 1'b1;
                    w_fin_ovf = 1'b1;
                end
            end else begin
                n_free_dec = i_in_beat.code_byte[6];
                w_dec_fin  = 1'b1;
                w_fin_ovf  = w_ovf_new;
            end
        end
    end

    // result selection
    always_comb begin
        w_load = 1'b0;
        w_res  = '0;
        if (i_cmd.accept && !w_is_enc) begin
            if (w_dec_fin) begin
                w_load         = 1'b1;
                w_res.size_out = 32'(n_acc);
                w_res.free_out = n_free_dec;
                w_res.code_len = 3'(n_cnt);
                w_res.last     = 1'b1;
                w_res.overflow = w_fin_ovf;
            end
        end else if ((i_cmd.accept && !o_sts.go_search && !o_sts.go_emit) ||
                     i_cmd.load_error) begin
            w_load         = 1'b1;
            w_res.last     = 1'b1;
            w_res.overflow = 1'b1;
        end else if (i_cmd.emit_byte) begin
            w_load         = 1'b1;
            w_res.out_byte = w_enc_byte;
            w_res.size_out = r_pay;
            w_res.free_out = r_free_enc;
            w_res.code_len = 3'(r_n);
            w_res.last     = (r_rem == '0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc       <= '0;
            r_cnt       <= '0;
            r_dir       <= DIR_IDLE;
            r_free_dec  <= 1'b0;
            r_ovf       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.accept && !w_is_enc) begin
                if (w_dec_fin) begin
                    r_acc      <= '0;
                    r_cnt      <= '0;
                    r_dir      <= DIR_IDLE;
                    r_free_dec <= 1'b0;
                    r_ovf      <= 1'b0;
                end else begin
                    r_acc      <= n_acc;
                    r_cnt      <= n_cnt;
                    r_dir      <= n_dir;
                    r_free_dec <= n_free_dec;
                    r_ovf      <= n_ovf;
                end
            end
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_out <= w_res;
        end
        if (i_cmd.accept && o_sts.go_emit) begin
            r_pay      <= i_in_beat.size_value;
            r_n        <= N_W'(w_need);
            r_rem      <= CNT_W'(w_need - 3'd1);
            r_first    <= 1'b1;
            r_free_enc <= i_in_beat.free_flag;
        end else if (i_cmd.accept && o_sts.go_search) begin
            r_v        <= i_in_beat.size_value;
            r_n        <= N_W'(1);
            r_free_enc <= i_in_beat.free_flag;
        end else if (i_cmd.search_step) begin
            if (!w_break) begin
                r_n <= r_n + N_W'(1);
            end else if (!w_n_over) begin
                r_pay   <= w_pay_try;
                r_rem   <= CNT_W'(r_n - N_W'(1));
                r_first <= 1'b1;
            end
        end else if (i_cmd.emit_byte) begin
            r_rem   <= r_rem - CNT_W'(1);
            r_first <= 1'b0;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_beat  = r_out;

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_load |-> o_sts.out_free)
        else $error("result loaded over a beat not yet taken");

    a_idle_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_dir == DIR_IDLE |-> (r_cnt == '0 && r_acc == '0 && !r_ovf))
        else $error("decode state left dirty while idle");

    a_ovf_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.overflow |-> r_out.last)
        else $error("overflow result not marked last");

endmodule

### rtl/core/boundary_tag_size_codec.sv
// Decode: one tag byte per cycle while the output is free; the tag's result registers with its final byte.
// Encode payload size: a setup step on accept, then one byte per cycle while the output is free.
// Encode internal size: adds a length search over candidate lengths, shortest first, before emission.
// A new item is taken once the encode sequencer is idle and the output register is free or being taken.
// Reset is synchronous, active low: clears the decode state, sequencer and output valid; no sweep.
module boundary_tag_size_codec #(
    parameter int SIZE_BITS      = btsc_pkg::SIZE_BITS_DEF,
    parameter int MAX_CODE_BYTES = btsc_pkg::MAX_CODE_BYTES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    btsc_chan_if.sink   i_in,
    btsc_chan_if.source o_out
);

    btsc_pkg::t_in_beat  w_in_beat;
    btsc_pkg::t_out_beat w_out_beat;
    btsc_pkg::t_cmd      w_cmd;
    btsc_pkg::t_sts      w_sts;
    logic                w_in_ready;
    logic                w_out_valid;

    assign w_in_beat     = i_in.payload;
    assign i_in.ready    = w_in_ready;
    assign o_out.valid   = w_out_valid;
    assign o_out.payload = w_out_beat;

    btsc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (w_in_ready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    btsc_dp #(
        .SIZE_BITS      (SIZE_BITS),
        .MAX_CODE_BYTES (MAX_CODE_BYTES)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_beat   (w_in_beat),
        .i_cmd       (w_cmd),
        .i_out_ready (o_out.ready),
        .o_sts       (w_sts),
        .o_out_valid (w_out_valid),
        .o_out_beat  (w_out_beat)
    );

endmodule
